// File: rtl/midipk_pkg.sv
`timescale 1ns / 1ps

package midipk_pkg;

  // parse mode of the byte stream
  typedef enum logic [2:0] {
    MODE_SCAN    = 3'd0,
    MODE_ONE     = 3'd1,
    MODE_TWO_A   = 3'd2,
    MODE_TWO_B   = 3'd3,
    MODE_SYSEX_0 = 3'd4,
    MODE_SYSEX_1 = 3'd5,
    MODE_SYSEX_2 = 3'd6
  } mode_e;

  // status bytes with a meaning of their own
  localparam logic [7:0] ST_REALTIME_LO = 8'hF8;
  localparam logic [7:0] ST_SYSTEM_LO   = 8'hF0;
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_MTC_QFRAME  = 8'hF1;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_ONE_PARAM_LO = 8'hC0;
  localparam logic [7:0] ST_ONE_PARAM_HI = 8'hDF;

  // code index numbers
  localparam logic [3:0] CIN_SYS_TWO    = 4'h2;
  localparam logic [3:0] CIN_SYS_THREE  = 4'h3;
  localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
  localparam logic [3:0] CIN_END_ONE    = 4'h5;
  localparam logic [3:0] CIN_END_TWO    = 4'h6;
  localparam logic [3:0] CIN_END_THREE  = 4'h7;
  localparam logic [3:0] CIN_SINGLE     = 4'hF;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  held_status;
    logic [7:0]  held_data_one;
    logic [7:0]  held_data_two;
  } parse_st_t;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [1:0] byte_count;
  } packet_t;

  // meaningful bytes per code index, zero for reserved codes
  function automatic logic [1:0] cin_len(input logic [3:0] cin);
    logic [1:0] n;
    unique case (cin)
      4'h0, 4'h1:                      n = 2'd0;
      4'h2, 4'h6, 4'hC, 4'hD:          n = 2'd2;
      4'h5, 4'hF:                      n = 2'd1;
      default:                         n = 2'd3;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/midipk_parse.sv
`timescale 1ns / 1ps

module midipk_parse (
  input  logic [7:0]           midi_b_i,
  input  midipk_pkg::parse_st_t st_i,
  output midipk_pkg::parse_st_t st_o,
  output logic                 emit_o,
  output midipk_pkg::packet_t  pkt_o
);
  import midipk_pkg::*;

  logic       cand;   // a packet is formed
  logic       load;   // packet bytes become the held bytes
  logic [3:0] cin;
  logic [7:0] b1, b2, b3;

  always_comb begin
    st_o = st_i;
    cand = 1'b0;
    load = 1'b0;
    cin  = '0;
    b1   = '0;
    b2   = '0;
    b3   = '0;
    if (midi_b_i >= ST_REALTIME_LO) begin
      cand = 1'b1;
      cin  = CIN_SINGLE;
      b1   = midi_b_i;
    end else if (midi_b_i >= ST_SYSTEM_LO) begin
      unique case (midi_b_i)
        ST_SYSEX_START: begin
          st_o.held_status = midi_b_i;
          st_o.mode        = MODE_SYSEX_1;
        end
        ST_MTC_QFRAME, ST_SONG_SEL: begin
          st_o.held_status = midi_b_i;
          st_o.mode        = MODE_ONE;
        end
        ST_SONG_POS: begin
          st_o.held_status = midi_b_i;
          st_o.mode        = MODE_TWO_A;
        end
        ST_TUNE_REQ: begin
          st_o.mode = MODE_SCAN;
          cand      = 1'b1;
          load      = 1'b1;
          cin       = CIN_END_ONE;
          b1        = ST_TUNE_REQ;
        end
        ST_SYSEX_END: begin
          st_o.mode = MODE_SCAN;
          priority if (st_i.mode == MODE_SYSEX_0) begin
            cand = 1'b1;
            load = 1'b1;
            cin  = CIN_END_ONE;
            b1   = ST_SYSEX_END;
          end else if (st_i.mode == MODE_SYSEX_1) begin
            cand = 1'b1;
            load = 1'b1;
            cin  = CIN_END_TWO;
            b1   = st_i.held_status;
            b2   = ST_SYSEX_END;
          end else if (st_i.mode == MODE_SYSEX_2) begin
            cand = 1'b1;
            load = 1'b1;
            cin  = CIN_END_THREE;
            b1   = st_i.held_status;
            b2   = st_i.held_data_one;
            b3   = ST_SYSEX_END;
          end else begin
            cand = 1'b0;
          end
        end
        default: begin
          // undefined system common status drops the parse
          st_o.mode = MODE_SCAN;
        end
      endcase
    end else if (midi_b_i[7]) begin
      st_o.held_status = midi_b_i;
      st_o.mode = (midi_b_i >= ST_ONE_PARAM_LO && midi_b_i <= ST_ONE_PARAM_HI) ?
                  MODE_ONE : MODE_TWO_A;
    end else begin
      unique case (st_i.mode)
        MODE_ONE: begin
          cand = 1'b1;
          load = 1'b1;
          if (st_i.held_status < ST_SYSTEM_LO) begin
            cin = st_i.held_status[7:4];
          end else begin
            cin       = CIN_SYS_TWO;
            st_o.mode = MODE_SCAN;
          end
          b1 = st_i.held_status;
          b2 = midi_b_i;
        end
        MODE_TWO_A: begin
          st_o.held_data_one = midi_b_i;
          st_o.mode          = MODE_TWO_B;
        end
        MODE_TWO_B: begin
          cand = 1'b1;
          load = 1'b1;
          if (st_i.held_status < ST_SYSTEM_LO) begin
            cin       = st_i.held_status[7:4];
            st_o.mode = MODE_TWO_A;
          end else begin
            cin       = CIN_SYS_THREE;
            st_o.mode = MODE_SCAN;
          end
          b1 = st_i.held_status;
          b2 = st_i.held_data_one;
          b3 = midi_b_i;
        end
        MODE_SYSEX_0: begin
          st_o.held_status = midi_b_i;
          st_o.mode        = MODE_SYSEX_1;
        end
        MODE_SYSEX_1: begin
          st_o.held_data_one = midi_b_i;
          st_o.mode          = MODE_SYSEX_2;
        end
        MODE_SYSEX_2: begin
          cand      = 1'b1;
          load      = 1'b1;
          cin       = CIN_SYSEX_CONT;
          st_o.mode = MODE_SYSEX_0;
          b1        = st_i.held_status;
          b2        = st_i.held_data_one;
          b3        = midi_b_i;
        end
        default: begin
          // data with no status in force is dropped
          cand = 1'b0;
        end
      endcase
    end
    if (load) begin
      st_o.held_status   = b1;
      st_o.held_data_one = b2;
      st_o.held_data_two = b3;
    end
  end

  assign pkt_o.code_index = cin;
  assign pkt_o.b1         = b1;
  assign pkt_o.b2         = b2;
  assign pkt_o.b3         = b3;
  assign pkt_o.byte_count = cin_len(cin);
  assign emit_o           = cand && (cin_len(cin) != 2'd0);

endmodule

// File: rtl/midi_to_usb_midi_packetizer.sv
`timescale 1ns / 1ps

// channel   dir  handshake                               payload
// midi_byte in   midi_byte_valid_i / midi_byte_ready_o    midi_byte_i
// packet    out  pkt_valid_o / pkt_ready_i                header_cable_o, code_index_o,
//                                                         packet_byte_one/two/three_o,
//                                                         byte_count_o
// config    in   cfg_we_i                                 cfg_wdata_i (cable number)
//
// one word per cycle unless a stalled packet holds the input: input register, one level of parse logic, packet register
// a word registered at the input is parsed, and any packet it forms enters the packet register once that is free
// words that form no packet retire without waiting on the packet side
// a stalled packet holds only words that would form a new packet
// rst_ni clears the parse state, the cable number and both valid flags

module midi_to_usb_midi_packetizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       midi_byte_valid_i,
  output logic       midi_byte_ready_o,
  input  logic [7:0] midi_byte_i,
  output logic       pkt_valid_o,
  input  logic       pkt_ready_i,
  output logic [3:0] header_cable_o,
  output logic [3:0] code_index_o,
  output logic [7:0] packet_byte_one_o,
  output logic [7:0] packet_byte_two_o,
  output logic [7:0] packet_byte_three_o,
  output logic [1:0] byte_count_o
);
  import midipk_pkg::*;

  logic       cable_we;
  logic [3:0] cable_num_q;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  parse_st_t  st_q, st_d;
  logic       emit;
  packet_t    pkt_d, pkt_q;
  logic [3:0] hdr_cable_q;
  logic       out_vld_q;
  logic       out_free;
  logic       advance;

  // parse logic on the registered word
  midipk_parse u_parse (
    .midi_b_i (in_byte_q),
    .st_i     (st_q),
    .st_o     (st_d),
    .emit_o   (emit),
    .pkt_o    (pkt_d)
  );

  assign out_free = !out_vld_q || pkt_ready_i;
  // the input word retires when it needs no packet slot or one is free
  assign advance           = in_vld_q && (!emit || out_free);
  assign midi_byte_ready_o = !in_vld_q || advance;

  assign cable_we = cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cable_num_q <= '0;
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      st_q        <= '{mode: MODE_SCAN, held_status: 8'h00,
                       held_data_one: 8'h00, held_data_two: 8'h00};
    end else begin
      if (cable_we) begin
        cable_num_q <= cfg_wdata_i;
      end
      if (midi_byte_ready_o) begin
        in_vld_q <= midi_byte_valid_i;
      end
      if (advance) begin
        st_q <= st_d;
      end
      if (advance && emit) begin
        out_vld_q <= 1'b1;
      end else if (pkt_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (midi_byte_valid_i && midi_byte_ready_o) begin
      in_byte_q <= midi_byte_i;
    end
    if (advance && emit) begin
      pkt_q       <= pkt_d;
      hdr_cable_q <= cable_num_q;
    end
  end

  assign pkt_valid_o         = out_vld_q;
  assign header_cable_o      = hdr_cable_q;
  assign code_index_o        = pkt_q.code_index;
  assign packet_byte_one_o   = pkt_q.b1;
  assign packet_byte_two_o   = pkt_q.b2;
  assign packet_byte_three_o = pkt_q.b3;
  assign byte_count_o        = pkt_q.byte_count;

endmodule
